>>> hdl/rgblab_pkg.sv
// ----------------------------------------------------------------------------
// rgblab_pkg
// Pixel types and fixed matrix coefficients for the RGB to l-alpha-beta
// converter.
// ----------------------------------------------------------------------------
package rgblab_pkg;

    localparam int CHAN_BITS = 8;
    localparam int OUT_BITS  = 16;
    localparam int LMS_BITS  = 24;   // Q8.16, always below 2^24
    localparam int MANT_BITS = 31;   // Q1.30 mantissa
    localparam int LOG_STEPS = 16;   // fraction bits of log2
    localparam int P_BITS    = 5;    // msb index of an LMS value
    localparam int L2_BITS   = 22;   // signed log2 in Q.16
    localparam int PROD_BITS = 46;
    localparam int LG_BITS   = 21;   // signed log10 in Q.16
    localparam int LCOEF_BITS = 17;
    localparam int LP_BITS   = LG_BITS + LCOEF_BITS;
    localparam int ACC_BITS  = LP_BITS + 2;

    localparam logic signed [23:0] LOG10_2_Q24 = 24'sd5050445;

    localparam logic [15:0] LMS_COEF [3][3] = '{
        '{16'd24976, 16'd37899, 16'd2635},
        '{16'd12891, 16'd47474, 16'd5125},
        '{16'd1579,  16'd8441,  16'd55339}
    };

    localparam logic signed [LCOEF_BITS-1:0] LAB_COEF [3][3] = '{
        '{17'sd37834,  17'sd37834,  17'sd37834},
        '{17'sd26752,  17'sd26752, -17'sd53504},
        '{17'sd46341, -17'sd46341,  17'sd0}
    };

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_rgb_pix;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] lightness;
        logic signed [OUT_BITS-1:0] alpha_chroma;
        logic signed [OUT_BITS-1:0] beta_chroma;
    } t_lab_pix;

endpackage

>>> hdl/rgb_to_lab_color_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_color_convert
// RGB pixel to l-alpha-beta (Q4.12) through LMS and base-10 logarithms.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while not stalled and returns one l-alpha-beta
// pixel per pixel, in order. The pipeline has 23 register stages: input, LMS
// matrix, leading-one normalize, sixteen mantissa squaring stages (one
// multiplier each, per channel) forming the log2 fraction, log10 scale, log10
// rounding, second matrix products, and the rounded, saturated output. A held
// result stalls the whole pipeline, and o_stall follows i_stall while the
// output register is full.
module rgb_to_lab_color_convert #(
    parameter int OUT_FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  rgblab_pkg::t_rgb_pix  i_pix,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rgblab_pkg::t_lab_pix  o_pix
);
    import rgblab_pkg::*;

    localparam int RND_SH = 32 - OUT_FRAC_BITS;

    // one squaring step: returns {fraction bit, next mantissa}
    function automatic logic [MANT_BITS:0] sq_step(input logic [MANT_BITS-1:0] m);
        logic [2*MANT_BITS-1:0] sq;
        logic [MANT_BITS:0]     t;
        sq = m * m;
        t  = sq[2*MANT_BITS-1:MANT_BITS-1];
        if (t[MANT_BITS]) begin
            sq_step = {1'b1, t[MANT_BITS:1]};
        end else begin
            sq_step = {1'b0, t[MANT_BITS-1:0]};
        end
    endfunction

    logic ce;

    logic                 r_v0;
    t_rgb_pix             r_pix;
    logic                 r_v1;
    logic [LMS_BITS-1:0]  r_lms [3];
    logic                 r_v2;
    logic [MANT_BITS-1:0] r_m2 [3];
    logic [P_BITS-1:0]    r_p2 [3];
    logic                 r_z2 [3];

    logic                 r_sv [LOG_STEPS];
    logic [MANT_BITS-1:0] r_sm [LOG_STEPS][3];
    logic [LOG_STEPS-1:0] r_sf [LOG_STEPS][3];
    logic [P_BITS-1:0]    r_sp [LOG_STEPS][3];
    logic                 r_sz [LOG_STEPS][3];

    logic                        r_v3;
    logic signed [PROD_BITS-1:0] r_prod [3];
    logic                        r_z3 [3];
    logic                        r_v4;
    logic signed [LG_BITS-1:0]   r_lg [3];
    logic                        r_v5;
    logic signed [LP_BITS-1:0]   r_lp [3][3];
    logic                        r_v6;
    t_lab_pix                    r_out;

    logic [LMS_BITS-1:0]  n_lms [3];
    logic [MANT_BITS-1:0] n_m2 [3];
    logic [P_BITS-1:0]    n_p2 [3];
    logic [MANT_BITS:0]   n_sq [LOG_STEPS][3];
    logic signed [PROD_BITS-1:0] n_prod [3];
    logic signed [OUT_BITS-1:0]  n_res [3];

    assign ce      = !(r_v6 && i_stall);
    assign o_stall = !ce;
    assign o_valid = r_v6;
    assign o_pix   = r_out;

    always_comb begin
        logic [CHAN_BITS-1:0]    ch [3];
        logic signed [L2_BITS-1:0]  l2;
        logic signed [ACC_BITS-1:0] acc;
        logic signed [ACC_BITS-1:0] sh;
        ch[0] = r_pix.red;
        ch[1] = r_pix.green;
        ch[2] = r_pix.blue;
        for (int r = 0; r < 3; r++) begin
            n_lms[r] = LMS_BITS'(LMS_COEF[r][0] * ch[0])
                     + LMS_BITS'(LMS_COEF[r][1] * ch[1])
                     + LMS_BITS'(LMS_COEF[r][2] * ch[2]);
            // leading-one position
            n_p2[r] = '0;
            for (int i = 0; i < LMS_BITS; i++) begin
                if (r_lms[r][i]) begin
                    n_p2[r] = P_BITS'(i);
                end
            end
            n_m2[r] = MANT_BITS'(r_lms[r]) << (P_BITS'(MANT_BITS - 1) - n_p2[r]);
            n_sq[0][r] = sq_step(r_m2[r]);
            for (int s = 1; s < LOG_STEPS; s++) begin
                n_sq[s][r] = sq_step(r_sm[s-1][r]);
            end
            l2 = {(6'(r_sp[LOG_STEPS-1][r]) - 6'd16), r_sf[LOG_STEPS-1][r]};
            n_prod[r] = PROD_BITS'(l2) * PROD_BITS'(LOG10_2_Q24);
            acc = ACC_BITS'(r_lp[r][0]) + ACC_BITS'(r_lp[r][1]) + ACC_BITS'(r_lp[r][2]);
            sh  = (acc + (ACC_BITS'(1) <<< (RND_SH - 1))) >>> RND_SH;
            if (sh > ACC_BITS'(32767)) begin
                n_res[r] = 16'sh7fff;
            end else if (sh < -ACC_BITS'(32768)) begin
                n_res[r] = -16'sh8000;
            end else begin
                n_res[r] = sh[OUT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            for (int s = 0; s < LOG_STEPS; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (ce) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_sv[0] <= r_v2;
            for (int s = 1; s < LOG_STEPS; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
            r_v3 <= r_sv[LOG_STEPS-1];
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pix <= i_pix;
            for (int r = 0; r < 3; r++) begin
                r_lms[r] <= n_lms[r];
                r_m2[r]  <= n_m2[r];
                r_p2[r]  <= n_p2[r];
                r_z2[r]  <= (r_lms[r] == '0);
                r_sm[0][r] <= n_sq[0][r][MANT_BITS-1:0];
                r_sf[0][r] <= LOG_STEPS'(n_sq[0][r][MANT_BITS]);
                r_sp[0][r] <= r_p2[r];
                r_sz[0][r] <= r_z2[r];
                for (int s = 1; s < LOG_STEPS; s++) begin
                    r_sm[s][r] <= n_sq[s][r][MANT_BITS-1:0];
                    r_sf[s][r] <= {r_sf[s-1][r][LOG_STEPS-2:0], n_sq[s][r][MANT_BITS]};
                    r_sp[s][r] <= r_sp[s-1][r];
                    r_sz[s][r] <= r_sz[s-1][r];
                end
                r_prod[r] <= n_prod[r];
                r_z3[r]   <= r_sz[LOG_STEPS-1][r];
                // zero channel gives a zero log
                if (r_z3[r]) begin
                    r_lg[r] <= '0;
                end else begin
                    r_lg[r] <= LG_BITS'((r_prod[r] + (PROD_BITS'(1) <<< 23)) >>> 24);
                end
                for (int c = 0; c < 3; c++) begin
                    r_lp[r][c] <= LP_BITS'(LAB_COEF[r][c]) * LP_BITS'(r_lg[c]);
                end
            end
            r_out.lightness    <= n_res[0];
            r_out.alpha_chroma <= n_res[1];
            r_out.beta_chroma  <= n_res[2];
        end
    end

endmodule
